FILE: sv/owm_pkg.sv
`default_nettype none
// shared types and constants for the one-wire bus master
package owm_pkg;

	localparam int unsigned REG_W  = 10;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W  = 3;

	typedef logic [REG_W-1:0] reg_val_t;

	// register indexes
	localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRES_WAIT     = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRES_LOW      = 3'd3;
	localparam logic [IDX_W-1:0] REG_READ_SAMPLE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_SLOT          = 3'd5;

	// register reset values
	localparam reg_val_t RST_RESET_LOW     = 10'd480;
	localparam reg_val_t RST_RESET_RELEASE = 10'd30;
	localparam reg_val_t RST_PRES_WAIT     = 10'd200;
	localparam reg_val_t RST_PRES_LOW      = 10'd240;
	localparam reg_val_t RST_READ_SAMPLE   = 10'd15;
	localparam reg_val_t RST_SLOT          = 10'd60;

	localparam reg_val_t ONE_TICK = 10'd1;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_RESET = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RST_LOW   = 4'd1,
		PH_RST_REL   = 4'd2,
		PH_PRES_WAIT = 4'd3,
		PH_PRES_LOW  = 4'd4,
		PH_W_LOW     = 4'd5,
		PH_W_REL     = 4'd6,
		PH_R_LOW     = 4'd7,
		PH_R_REL     = 4'd8,
		PH_R_REC     = 4'd9
	} phase_t;

	typedef struct packed {
		reg_val_t reset_low_ticks;
		reg_val_t reset_release_ticks;
		reg_val_t presence_wait_limit;
		reg_val_t presence_low_limit;
		reg_val_t read_sample_ticks;
		reg_val_t slot_ticks;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence_error;
		logic [7:0] read_data;
	} res_t;

endpackage
`default_nettype wire

FILE: sv/owm_cfg.sv
`default_nettype none
// apb register file for the one-wire bus master timing registers
module owm_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [owm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [owm_pkg::DATA_W-1:0] pwdata,
	output logic      [owm_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output owm_pkg::cfg_t                   cfg
);

	owm_pkg::cfg_t                 cfg_q;
	logic [owm_pkg::IDX_W-1:0]     idx;
	logic                          wr_en;
	owm_pkg::reg_val_t             wval;
	owm_pkg::reg_val_t             rval;

	assign idx    = paddr[owm_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign wval   = pwdata[owm_pkg::REG_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= owm_pkg::RST_RESET_LOW;
			cfg_q.reset_release_ticks <= owm_pkg::RST_RESET_RELEASE;
			cfg_q.presence_wait_limit <= owm_pkg::RST_PRES_WAIT;
			cfg_q.presence_low_limit  <= owm_pkg::RST_PRES_LOW;
			cfg_q.read_sample_ticks   <= owm_pkg::RST_READ_SAMPLE;
			cfg_q.slot_ticks          <= owm_pkg::RST_SLOT;
		end else if (wr_en) begin
			case (idx)
				owm_pkg::REG_RESET_LOW:     cfg_q.reset_low_ticks     <= wval;
				owm_pkg::REG_RESET_RELEASE: cfg_q.reset_release_ticks <= wval;
				owm_pkg::REG_PRES_WAIT:     cfg_q.presence_wait_limit <= wval;
				owm_pkg::REG_PRES_LOW:      cfg_q.presence_low_limit  <= wval;
				owm_pkg::REG_READ_SAMPLE:   cfg_q.read_sample_ticks   <= wval;
				owm_pkg::REG_SLOT:          cfg_q.slot_ticks          <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			owm_pkg::REG_RESET_LOW:     rval = cfg_q.reset_low_ticks;
			owm_pkg::REG_RESET_RELEASE: rval = cfg_q.reset_release_ticks;
			owm_pkg::REG_PRES_WAIT:     rval = cfg_q.presence_wait_limit;
			owm_pkg::REG_PRES_LOW:      rval = cfg_q.presence_low_limit;
			owm_pkg::REG_READ_SAMPLE:   rval = cfg_q.read_sample_ticks;
			owm_pkg::REG_SLOT:          rval = cfg_q.slot_ticks;
			default:                    rval = '0;
		endcase
		prdata = owm_pkg::DATA_W'(rval);
	end

endmodule
`default_nettype wire

FILE: sv/owm_seq.sv
`default_nettype none
// bus sequencer state and single-beat next-state logic
module owm_seq #(
	parameter int unsigned TICK_COUNT_BITS = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [1:0]    kind,
	input  wire logic [7:0]    data_byte,
	input  wire logic          line_level,
	input  wire owm_pkg::cfg_t cfg,
	output owm_pkg::res_t      res
);

	localparam int unsigned CW = TICK_COUNT_BITS;
	localparam int unsigned NW = TICK_COUNT_BITS + 1;

	owm_pkg::phase_t   phase_q, phase_d;
	logic [CW-1:0]     count_q, count_d;
	logic [3:0]        bit_idx_q, bit_idx_d;
	logic [7:0]        shift_q, shift_d;
	logic              err_q, err_d;
	logic [7:0]        last_rd_q, last_rd_d;

	owm_pkg::reg_val_t lim;
	logic [CW-1:0]     base;
	logic [NW-1:0]     cnt_inc;
	logic              hit;
	logic              rec_end;
	logic              done;
	logic              bit0;
	logic [3:0]        bit_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= owm_pkg::PH_IDLE;
			count_q   <= '0;
			bit_idx_q <= '0;
			shift_q   <= '0;
			err_q     <= 1'b0;
			last_rd_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			err_q     <= err_d;
			last_rd_q <= last_rd_d;
		end
	end

	always_comb begin
		bit0    = shift_q[0];
		bit_inc = bit_idx_q + 4'd1;
		case (phase_q)
			owm_pkg::PH_RST_LOW:   lim = cfg.reset_low_ticks;
			owm_pkg::PH_RST_REL:   lim = cfg.reset_release_ticks;
			owm_pkg::PH_PRES_WAIT: lim = line_level ? cfg.presence_wait_limit
			                                        : cfg.presence_low_limit;
			owm_pkg::PH_PRES_LOW:  lim = cfg.presence_low_limit;
			owm_pkg::PH_W_LOW:     lim = bit0 ? owm_pkg::ONE_TICK : cfg.slot_ticks;
			owm_pkg::PH_W_REL:     lim = bit0 ? cfg.slot_ticks : owm_pkg::ONE_TICK;
			owm_pkg::PH_R_REL:     lim = cfg.read_sample_ticks;
			default:               lim = cfg.slot_ticks;
		endcase
		base    = (phase_q == owm_pkg::PH_PRES_WAIT && !line_level) ? '0 : count_q;
		cnt_inc = NW'(base) + NW'(1);
		hit     = cnt_inc >= NW'(lim);
		rec_end = hit || (NW'(count_q) >= NW'(cfg.slot_ticks));

		phase_d   = phase_q;
		count_d   = count_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		err_d     = err_q;
		last_rd_d = last_rd_q;
		done      = 1'b0;

		if (kind != owm_pkg::KIND_TICK) begin
			if (phase_q == owm_pkg::PH_IDLE) begin
				count_d   = '0;
				bit_idx_d = '0;
				case (kind)
					owm_pkg::KIND_RESET: phase_d = owm_pkg::PH_RST_LOW;
					owm_pkg::KIND_WRITE: begin
						shift_d = data_byte;
						phase_d = owm_pkg::PH_W_LOW;
					end
					default: begin
						shift_d = '0;
						phase_d = owm_pkg::PH_R_LOW;
					end
				endcase
			end
		end else begin
			case (phase_q)
				owm_pkg::PH_RST_LOW, owm_pkg::PH_RST_REL: begin
					count_d = hit ? '0 : cnt_inc[CW-1:0];
					if (hit) begin
						phase_d = (phase_q == owm_pkg::PH_RST_LOW) ? owm_pkg::PH_RST_REL
						                                           : owm_pkg::PH_PRES_WAIT;
					end
				end
				owm_pkg::PH_PRES_WAIT: begin
					count_d = hit ? '0 : cnt_inc[CW-1:0];
					if (!line_level) phase_d = owm_pkg::PH_PRES_LOW;
					if (hit) begin
						err_d = 1'b1;
						done  = 1'b1;
					end
				end
				owm_pkg::PH_PRES_LOW: begin
					if (line_level) begin
						err_d = 1'b0;
						done  = 1'b1;
					end else begin
						count_d = hit ? '0 : cnt_inc[CW-1:0];
						if (hit) begin
							err_d = 1'b1;
							done  = 1'b1;
						end
					end
				end
				owm_pkg::PH_W_LOW: begin
					count_d = hit ? '0 : cnt_inc[CW-1:0];
					if (hit) phase_d = owm_pkg::PH_W_REL;
				end
				owm_pkg::PH_W_REL: begin
					count_d = hit ? '0 : cnt_inc[CW-1:0];
					if (hit) begin
						shift_d   = {1'b0, shift_q[7:1]};
						bit_idx_d = bit_inc;
						if (bit_inc >= 4'd8) done = 1'b1;
						else phase_d = owm_pkg::PH_W_LOW;
					end
				end
				owm_pkg::PH_R_LOW: begin
					count_d = CW'(1);
					phase_d = owm_pkg::PH_R_REL;
				end
				owm_pkg::PH_R_REL: begin
					count_d = cnt_inc[CW-1:0];
					if (hit) begin
						shift_d = {line_level, shift_q[7:1]};
						phase_d = owm_pkg::PH_R_REC;
					end
				end
				owm_pkg::PH_R_REC: begin
					if (rec_end) begin
						count_d   = '0;
						bit_idx_d = bit_inc;
						if (bit_inc >= 4'd8) begin
							last_rd_d = shift_q;
							done      = 1'b1;
						end else begin
							phase_d = owm_pkg::PH_R_LOW;
						end
					end else begin
						count_d = cnt_inc[CW-1:0];
					end
				end
				default: phase_d = owm_pkg::PH_IDLE;
			endcase
			if (done) begin
				phase_d = owm_pkg::PH_IDLE;
				count_d = '0;
			end
		end

		res.drive_low      = (phase_d == owm_pkg::PH_RST_LOW) || (phase_d == owm_pkg::PH_W_LOW)
		                  || (phase_d == owm_pkg::PH_R_LOW);
		res.busy           = phase_d != owm_pkg::PH_IDLE;
		res.done           = done;
		res.presence_error = err_d;
		res.read_data      = last_rd_d;
	end

endmodule
`default_nettype wire

FILE: sv/one_wire_master.sv
`default_nettype none
// top level of the one-wire bus master: beat registers, sequencer and registers
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_stall | kind, data_byte, line_level
//  out     | out_valid/out_stall | drive_low, busy_res, done_res, presence_error,
//          |                     | read_data
//  config  | apb                 | paddr, pwdata, prdata
//
//  one beat in and one beat out every cycle while out_stall is low; a result passes
//  through the input register, then the result register after the sequencer
//  reset clears the sequencer to idle and loads the default timing registers
//  out_stall holds the result register; the input register keeps taking beats
//  until it is full, then in_stall rises
module one_wire_master #(
	parameter int unsigned TICK_COUNT_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 kind,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       line_level,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            drive_low,
	output logic                            busy_res,
	output logic                            done_res,
	output logic                            presence_error,
	output logic [7:0]                      read_data,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [owm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [owm_pkg::DATA_W-1:0] pwdata,
	output logic      [owm_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);

	owm_pkg::cfg_t cfg;
	owm_pkg::res_t res;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] data_s1;
	logic       line_s1;
	logic       out_valid_q;
	owm_pkg::res_t res_q;
	logic       out_free;
	logic       step;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (out_free) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			data_s1 <= data_byte;
			line_s1 <= line_level;
		end
		if (step) res_q <= res;
	end

	owm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	owm_seq #(
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.kind       (kind_s1),
		.data_byte  (data_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	assign out_valid      = out_valid_q;
	assign drive_low      = res_q.drive_low;
	assign busy_res       = res_q.busy;
	assign done_res       = res_q.done;
	assign presence_error = res_q.presence_error;
	assign read_data      = res_q.read_data;

endmodule
`default_nettype wire

FILE: bench/owm_bus_checker.sv
// status beat predictor and comparator for the one-wire bus master, with register readback checks
module owm_bus_checker #(
	parameter int unsigned TICK_COUNT_BITS = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         line_level,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic                         drive_low,
	input  wire logic                         busy_res,
	input  wire logic                         done_res,
	input  wire logic                         presence_error,
	input  wire logic [7:0]                   read_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [owm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [owm_pkg::DATA_W-1:0]   pwdata,
	input  wire logic [owm_pkg::DATA_W-1:0]   prdata,
	input  wire logic                         pready,
	output int                                fail_total,
	output int                                status_owed
);

	owm_pkg::reg_val_t          timing [6];
	owm_pkg::phase_t            ph;
	logic [TICK_COUNT_BITS-1:0] ticks;
	logic [3:0]                 bit_pos;
	logic [7:0]                 shifter;
	logic                       pres_err;
	logic [7:0]                 read_byte;
	owm_pkg::res_t              status_due [$];
	int                         errors;

	function automatic logic count_to(int unsigned limit);
		int unsigned n;
		n = 32'(ticks);
		n = n + 1;
		if (n >= limit) begin
			ticks = '0;
			count_to = 1'b1;
		end else begin
			ticks = n[TICK_COUNT_BITS-1:0];
			count_to = 1'b0;
		end
	endfunction

	function automatic logic bit_finished();
		bit_pos = bit_pos + 4'd1;
		ticks = '0;
		bit_finished = (bit_pos >= 4'd8);
	endfunction

	function automatic owm_pkg::res_t step_sequencer(logic [1:0] k, logic [7:0] d, logic ln);
		owm_pkg::res_t r;
		logic          fin;
		logic          lsb;
		int unsigned   n;
		fin = 1'b0;
		lsb = shifter[0];
		if (k != owm_pkg::KIND_TICK) begin
			if (ph == owm_pkg::PH_IDLE) begin
				ticks = '0;
				bit_pos = '0;
				case (k)
					owm_pkg::KIND_RESET: ph = owm_pkg::PH_RST_LOW;
					owm_pkg::KIND_WRITE: begin
						shifter = d;
						ph = owm_pkg::PH_W_LOW;
					end
					default: begin
						shifter = '0;
						ph = owm_pkg::PH_R_LOW;
					end
				endcase
			end
		end else begin
			case (ph)
				owm_pkg::PH_RST_LOW:
					if (count_to(timing[owm_pkg::REG_RESET_LOW])) ph = owm_pkg::PH_RST_REL;
				owm_pkg::PH_RST_REL:
					if (count_to(timing[owm_pkg::REG_RESET_RELEASE])) ph = owm_pkg::PH_PRES_WAIT;
				owm_pkg::PH_PRES_WAIT: begin
					if (ln) begin
						if (count_to(timing[owm_pkg::REG_PRES_WAIT])) begin
							pres_err = 1'b1;
							fin = 1'b1;
						end
					end else begin
						ticks = '0;
						ph = owm_pkg::PH_PRES_LOW;
						if (count_to(timing[owm_pkg::REG_PRES_LOW])) begin
							pres_err = 1'b1;
							fin = 1'b1;
						end
					end
				end
				owm_pkg::PH_PRES_LOW: begin
					if (ln) begin
						pres_err = 1'b0;
						fin = 1'b1;
					end else if (count_to(timing[owm_pkg::REG_PRES_LOW])) begin
						pres_err = 1'b1;
						fin = 1'b1;
					end
				end
				owm_pkg::PH_W_LOW:
					if (count_to(lsb ? owm_pkg::ONE_TICK : timing[owm_pkg::REG_SLOT]))
						ph = owm_pkg::PH_W_REL;
				owm_pkg::PH_W_REL: begin
					if (count_to(lsb ? timing[owm_pkg::REG_SLOT] : owm_pkg::ONE_TICK)) begin
						shifter = shifter >> 1;
						if (bit_finished()) fin = 1'b1;
						else ph = owm_pkg::PH_W_LOW;
					end
				end
				owm_pkg::PH_R_LOW: begin
					ticks = TICK_COUNT_BITS'(1);
					ph = owm_pkg::PH_R_REL;
				end
				owm_pkg::PH_R_REL: begin
					n = 32'(ticks);
					n = n + 1;
					ticks = n[TICK_COUNT_BITS-1:0];
					if (n >= timing[owm_pkg::REG_READ_SAMPLE]) begin
						shifter = {ln, shifter[7:1]};
						ph = owm_pkg::PH_R_REC;
					end
				end
				owm_pkg::PH_R_REC: begin
					n = 32'(ticks);
					if (n + 1 >= timing[owm_pkg::REG_SLOT] || n >= timing[owm_pkg::REG_SLOT]) begin
						if (bit_finished()) begin
							read_byte = shifter;
							fin = 1'b1;
						end else begin
							ph = owm_pkg::PH_R_LOW;
						end
					end else begin
						ticks = ticks + 1'b1;
					end
				end
				default: ph = owm_pkg::PH_IDLE;
			endcase
			if (fin) begin
				ph = owm_pkg::PH_IDLE;
				ticks = '0;
			end
		end
		r.drive_low = (ph == owm_pkg::PH_RST_LOW) || (ph == owm_pkg::PH_W_LOW)
			|| (ph == owm_pkg::PH_R_LOW);
		r.busy = (ph != owm_pkg::PH_IDLE);
		r.done = fin;
		r.presence_error = pres_err;
		r.read_data = read_byte;
		step_sequencer = r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		owm_pkg::res_t             want;
		logic [owm_pkg::IDX_W-1:0] idx;
		if (!arst_n) begin
			timing[owm_pkg::REG_RESET_LOW] = owm_pkg::RST_RESET_LOW;
			timing[owm_pkg::REG_RESET_RELEASE] = owm_pkg::RST_RESET_RELEASE;
			timing[owm_pkg::REG_PRES_WAIT] = owm_pkg::RST_PRES_WAIT;
			timing[owm_pkg::REG_PRES_LOW] = owm_pkg::RST_PRES_LOW;
			timing[owm_pkg::REG_READ_SAMPLE] = owm_pkg::RST_READ_SAMPLE;
			timing[owm_pkg::REG_SLOT] = owm_pkg::RST_SLOT;
			ph = owm_pkg::PH_IDLE;
			ticks = '0;
			bit_pos = '0;
			shifter = '0;
			pres_err = 1'b0;
			read_byte = '0;
			status_due.delete();
			errors = 0;
			fail_total <= 0;
			status_owed <= 0;
		end else begin
			idx = paddr[owm_pkg::ADDR_W-1:2];
			if (psel && penable && pready && idx <= owm_pkg::REG_SLOT) begin
				if (pwrite) begin
					timing[idx] = pwdata[owm_pkg::REG_W-1:0];
				end else if (prdata !== owm_pkg::DATA_W'(timing[idx])) begin
					$display("%0t: register %0d expected %0h actual %0h", $time, idx,
						timing[idx], prdata);
					errors++;
				end
			end
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$display("%0t: status beat with nothing owed, expected none actual %0h",
						$time, {drive_low, busy_res, done_res, presence_error, read_data});
					errors++;
				end else begin
					want = status_due.pop_front();
					check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
					check_field("busy_res", 8'(want.busy), 8'(busy_res));
					check_field("done_res", 8'(want.done), 8'(done_res));
					check_field("presence_error", 8'(want.presence_error), 8'(presence_error));
					check_field("read_data", want.read_data, read_data);
				end
			end
			if (in_valid && !in_stall)
				status_due.push_back(step_sequencer(kind, data_byte, line_level));
			fail_total <= errors;
			status_owed <= status_due.size();
		end
	end

endmodule

FILE: bench/one_wire_master_test.sv
// stimulus and verdict for the one-wire bus master
module one_wire_master_test;

	localparam int unsigned CNT_BITS       = 10;
	localparam int unsigned RANDOM_ITEMS   = 500;
	localparam int unsigned PHASE_ITEMS    = 110;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SEQ_TICK_CAP   = 8000;
	localparam int          HOLD_CYCLES    = 300;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [1:0]                 kind = owm_pkg::KIND_TICK;
	logic [7:0]                 data_byte = '0;
	logic                       line_level = 1'b1;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       drive_low;
	logic                       busy_res;
	logic                       done_res;
	logic                       presence_error;
	logic [7:0]                 read_data;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [owm_pkg::ADDR_W-1:0] paddr = '0;
	logic [owm_pkg::DATA_W-1:0] pwdata = '0;
	logic [owm_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	int                 fail_total;
	int                 status_owed;
	int                 seq_done_total = 0;
	logic               last_busy = 1'b0;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	logic               hold_request = 1'b0;
	logic               hold_taken = 1'b0;
	int                 hold_left = 0;
	int                 quiet_cycles = 0;
	int unsigned        items_sent = 0;
	owm_pkg::reg_val_t  plan [6];

	one_wire_master #(.TICK_COUNT_BITS(CNT_BITS)) uut (.*);
	owm_bus_checker #(.TICK_COUNT_BITS(CNT_BITS)) watcher (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_request && !hold_taken) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			last_busy <= busy_res;
			if (done_res) seq_done_total <= seq_done_total + 1;
		end
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("one_wire_master verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(logic [1:0] k, logic [7:0] d, logic ln);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= d;
		line_level <= ln;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic apb_access(logic wr, logic [owm_pkg::IDX_W-1:0] idx, owm_pkg::reg_val_t v);
		logic [owm_pkg::DATA_W-1:0] word;
		word = $urandom;
		word[owm_pkg::REG_W-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_owed != 0);
	endtask

	// drain any running sequence, then write and read back every timing register
	task automatic load_plan();
		int unsigned guard;
		guard = 0;
		settle();
		while (last_busy && guard < SEQ_TICK_CAP) begin
			send_item(owm_pkg::KIND_TICK, 8'($urandom), 1'b1);
			settle();
			guard++;
		end
		for (int i = 0; i <= owm_pkg::REG_SLOT; i++)
			apb_access(1'b1, owm_pkg::IDX_W'(i), plan[i]);
		for (int i = 0; i <= owm_pkg::REG_SLOT; i++)
			apb_access(1'b0, owm_pkg::IDX_W'(i), '0);
	endtask

	// one command, then ticks until its done beat comes back; reset line goes low
	// for low_len ticks from tick low_at
	task automatic run_sequence(logic [1:0] k, logic [7:0] d, logic intrude,
		int unsigned low_at, int unsigned low_len);
		int          target;
		int unsigned n;
		logic        ln;
		target = seq_done_total + 1;
		send_item(k, d, 1'($urandom));
		items_sent++;
		if (intrude)
			send_item(2'($urandom_range(owm_pkg::KIND_RESET, owm_pkg::KIND_READ)),
				8'($urandom), 1'($urandom));
		n = 0;
		while (seq_done_total < target && n < SEQ_TICK_CAP) begin
			if (n < 2 && $urandom_range(15) == 0) begin
				send_item(2'($urandom_range(owm_pkg::KIND_RESET, owm_pkg::KIND_READ)),
					8'($urandom), 1'($urandom));
			end else begin
				if (k == owm_pkg::KIND_RESET) ln = !(n >= low_at && n < low_at + low_len);
				else ln = 1'($urandom);
				send_item(owm_pkg::KIND_TICK, 8'($urandom), ln);
				items_sent++;
				n++;
			end
		end
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		int unsigned lo;
		int          phase;
		logic [1:0]  k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 11;
		recv_idle_pct <= 73;
		for (int i = 0; i <= owm_pkg::REG_SLOT; i++)
			apb_access(1'b0, owm_pkg::IDX_W'(i), '0);

		// zero timing values act as one tick
		plan = '{10'd0, 10'd0, 10'd3, 10'd3, 10'd0, 10'd0};
		load_plan();
		run_sequence(owm_pkg::KIND_RESET, 8'h00, 1'b1, SEQ_TICK_CAP, 0);
		run_sequence(owm_pkg::KIND_RESET, 8'hFF, 1'b0, 2, 1);
		run_sequence(owm_pkg::KIND_RESET, 8'h00, 1'b0, 2, SEQ_TICK_CAP);
		send_item(owm_pkg::KIND_TICK, 8'hFF, 1'b0);
		run_sequence(owm_pkg::KIND_WRITE, 8'h00, 1'b1, 0, 0);
		run_sequence(owm_pkg::KIND_WRITE, 8'hFF, 1'b0, 0, 0);
		run_sequence(owm_pkg::KIND_READ, 8'hFF, 1'b1, 0, 0);

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 11;
				recv_idle_pct <= 73;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 73;
				recv_idle_pct <= 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			for (int i = 0; i <= owm_pkg::REG_SLOT; i++) begin
				lo = (i >= owm_pkg::REG_READ_SAMPLE) ? 2 : 1;
				if (phase == 0) plan[i] = owm_pkg::reg_val_t'(lo);
				else if ($urandom_range(3) == 0)
					plan[i] = owm_pkg::reg_val_t'($urandom_range(lo, 24));
				else plan[i] = owm_pkg::reg_val_t'($urandom_range(lo, 6));
			end
			load_plan();
			if (phase == 1) hold_request <= 1'b1;
			phase_start = items_sent;
			while (items_sent < phase_start + PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
				k = 2'($urandom_range(owm_pkg::KIND_RESET, owm_pkg::KIND_READ));
				run_sequence(k, 8'($urandom), 1'b0,
					$urandom_range(0, plan[owm_pkg::REG_RESET_LOW] +
						plan[owm_pkg::REG_RESET_RELEASE] + plan[owm_pkg::REG_PRES_WAIT] + 2),
					$urandom_range(1, plan[owm_pkg::REG_PRES_LOW] + 2));
				if ($urandom_range(3) == 0)
					send_item(owm_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
			end
			phase++;
		end

		// long bus reset, widest presence limits, pulse shortly after the release window
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		plan = '{10'd300, 10'd2, 10'd1023, 10'd1023, 10'd1023, 10'd1023};
		load_plan();
		run_sequence(owm_pkg::KIND_RESET, 8'($urandom), 1'b0, 305, 4);

		settle();
		repeat (4) @(posedge clk);
		if (fail_total == 0) begin
			$display("one_wire_master verification clean");
		end else begin
			$display("one_wire_master verification failed");
		end
		$finish;
	end

endmodule
